/* rtl/clle_pkg.sv */
// ----------------------------------------------------------------------------
// clle_pkg
// Shared constants, operation codes and link-store request type for the
// cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

  // Pool geometry
  localparam int POOL_NODES = 64;
  localparam int NODE_BITS  = $clog2(POOL_NODES);
  localparam int VALUE_BITS = 32;
  localparam int STEP_BITS  = $clog2(POOL_NODES + 1);

  // Stream widths
  localparam int OP_BITS       = 3;
  localparam int IN_DATA_BITS  = ((2 * NODE_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((NODE_BITS + 1 + 7) / 8) * 8;

  typedef logic [NODE_BITS-1:0] node_t;

  // Operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_MAKE_EMPTY    = 3'd0,
    OP_INSERT        = 3'd1,
    OP_DELETE        = 3'd2,
    OP_FIND          = 3'd3,
    OP_FIND_PREVIOUS = 3'd4,
    OP_IS_EMPTY      = 3'd5,
    OP_IS_LAST       = 3'd6,
    OP_DELETE_LIST   = 3'd7
  } op_e;

  // Result status codes
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  // One cycle's access to the next-link store
  typedef struct packed {
    logic  re;
    node_t raddr;
    logic  we;
    node_t waddr;
    node_t wdata;
  } link_req_t;

endpackage

/* rtl/clle_ram.sv */
// ----------------------------------------------------------------------------
// clle_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/clle_link_store.sv */
// ----------------------------------------------------------------------------
// clle_link_store
// Next-link table. A RAM plus one valid bit per entry: an entry never
// written since reset reads as its pristine free-chain link (i+1, last 0).
// ----------------------------------------------------------------------------
module clle_link_store
  import clle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  link_req_t req_i,
  output node_t     rdata_o
);

  logic [POOL_NODES-1:0] valid_q;
  node_t                 raddr_q;
  logic                  hit_q;
  node_t                 ram_rdata;
  node_t                 init_link;

  clle_ram #(
    .WIDTH(NODE_BITS),
    .DEPTH(POOL_NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.re),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  // Written marks and the read-side tag that goes with the RAM output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      raddr_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        raddr_q <= req_i.raddr;
        hit_q   <= valid_q[req_i.raddr];
      end
    end
  end

  // Reset-time link of the entry last read
  assign init_link = (raddr_q == node_t'(POOL_NODES - 1)) ? '0 : raddr_q + node_t'(1);
  assign rdata_o   = hit_q ? ram_rdata : init_link;

endmodule

/* rtl/cursor_linked_list_engine_core.sv */
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// Linked lists in a fixed node pool with a free list headed by node 0.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transfer: tuser holds the operation,
//   tdata holds list_head, position and value. Master stream returns exactly
//   one result per command: node_index and flag in tdata, status in tuser.
//   Commands run one at a time; s_axis_tready is high only while the
//   sequencer is idle.
// Sequencing (accept to result valid):
//   is_empty / is_last read one link; make_empty and insert take a node off
//   the free list and stop early when out of space.
//   find / find_previous walk the list node by node, stopping on a hit;
//   delete then unlinks the found node and returns it to the free list.
//   delete_list detaches the list and frees its nodes one by one.
//   The worst case is a walk over the whole pool. The time taken
//   is set by the single read port of the link RAM: one link read per
//   node, with the value RAM read alongside it.
// Reset: the link table reads as one free chain through per-entry written
//   marks, so there is no clearing pass; the first command is taken at once.
// Stall: a finished result sits in the output register; the next command
//   is accepted meanwhile, and its final step waits until the register frees.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core
  import clle_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Commands
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // list_head, position, value
  input  logic [OP_BITS-1:0]       s_axis_tuser,  // operation
  // Results
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // node_index, flag
  output logic                     m_axis_tuser   // status
);

  typedef enum logic [24:0] {
    S_IDLE     = 25'h0000001,
    S_TAKE_RD  = 25'h0000002,
    S_TAKE_CHK = 25'h0000004,
    S_TAKE_UPD = 25'h0000008,
    S_MK_WR    = 25'h0000010,
    S_INS_RD   = 25'h0000020,
    S_INS_LNK  = 25'h0000040,
    S_INS_POS  = 25'h0000080,
    S_WALK_RD  = 25'h0000100,
    S_WALK_NX  = 25'h0000200,
    S_WALK_CMP = 25'h0000400,
    S_DEL_LNK  = 25'h0000800,
    S_DEL_FRD  = 25'h0001000,
    S_DEL_FWR  = 25'h0002000,
    S_DEL_FHD  = 25'h0004000,
    S_TEST_RD  = 25'h0008000,
    S_TEST_CHK = 25'h0010000,
    S_DL_RD    = 25'h0020000,
    S_DL_CUT   = 25'h0040000,
    S_DL_FRD   = 25'h0080000,
    S_DL_FCAP  = 25'h0100000,
    S_DL_LOOP  = 25'h0200000,
    S_DL_STEP  = 25'h0400000,
    S_DL_END   = 25'h0800000,
    S_DONE     = 25'h1000000
  } state_e;

  state_e state_q, state_d;

  // Command registers
  op_e                           op_q;
  node_t                         head_q, pos_q;
  logic signed [VALUE_BITS-1:0]  val_q;

  // Working registers
  node_t                  p_q, p_d;      // walk cursor / predecessor
  node_t                  t_q, t_d;      // node taken or matched
  node_t                  tn_q, tn_d;    // link of the matched node
  node_t                  fh_q, fh_d;    // free-list head while freeing
  logic [STEP_BITS-1:0]   steps_q, steps_d;

  // Pending result
  node_t res_idx_q, res_idx_d;
  logic  res_flag_q, res_flag_d;
  logic  res_status_q, res_status_d;

  // Output register
  logic  m_valid_q;
  node_t m_idx_q;
  logic  m_flag_q, m_status_q;

  // Memory access
  link_req_t                     link_req;
  node_t                         link_rdata;
  logic                          val_re, val_we;
  node_t                         val_raddr, val_waddr;
  logic signed [VALUE_BITS-1:0]  val_wdata, val_rdata;

  logic in_fire, out_fire, out_free, walk_end;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign walk_end = (steps_q == STEP_BITS'(POOL_NODES));

  clle_link_store u_links (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .rdata_o(link_rdata)
  );

  clle_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(POOL_NODES)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    t_d          = t_q;
    tn_d         = tn_q;
    fh_d         = fh_q;
    steps_d      = steps_q;
    res_idx_d    = res_idx_q;
    res_flag_d   = res_flag_q;
    res_status_d = res_status_q;
    link_req     = '0;
    val_re       = 1'b0;
    val_raddr    = '0;
    val_we       = 1'b0;
    val_waddr    = t_q;
    val_wdata    = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_idx_d    = '0;
          res_flag_d   = 1'b0;
          res_status_d = ST_OK;
          steps_d      = '0;
          unique case (op_e'(s_axis_tuser)) inside
            OP_MAKE_EMPTY, OP_INSERT:                state_d = S_TAKE_RD;
            OP_DELETE, OP_FIND, OP_FIND_PREVIOUS:    state_d = S_WALK_RD;
            OP_IS_EMPTY, OP_IS_LAST:                 state_d = S_TEST_RD;
            OP_DELETE_LIST:                          state_d = S_DL_RD;
            default:                                 state_d = S_IDLE;
          endcase
        end
      end

      // Take a node off the free list
      S_TAKE_RD: begin
        link_req.re    = 1'b1;
        link_req.raddr = '0;
        state_d        = S_TAKE_CHK;
      end
      S_TAKE_CHK: begin
        t_d = link_rdata;
        if (link_rdata == '0) begin
          res_status_d = ST_NO_SPACE;
          state_d      = S_DONE;
        end else begin
          link_req.re    = 1'b1;
          link_req.raddr = link_rdata;
          res_idx_d      = link_rdata;
          state_d        = S_TAKE_UPD;
        end
      end
      S_TAKE_UPD: begin
        link_req.we    = 1'b1;
        link_req.waddr = '0;
        link_req.wdata = link_rdata;
        state_d        = (op_q == OP_INSERT) ? S_INS_RD : S_MK_WR;
      end
      S_MK_WR: begin
        link_req.we    = 1'b1;
        link_req.waddr = t_q;
        link_req.wdata = '0;
        state_d        = S_DONE;
      end

      // Splice the new node in after position
      S_INS_RD: begin
        val_we         = 1'b1;
        link_req.re    = 1'b1;
        link_req.raddr = pos_q;
        state_d        = S_INS_LNK;
      end
      S_INS_LNK: begin
        link_req.we    = 1'b1;
        link_req.waddr = t_q;
        link_req.wdata = link_rdata;
        state_d        = S_INS_POS;
      end
      S_INS_POS: begin
        link_req.we    = 1'b1;
        link_req.waddr = pos_q;
        link_req.wdata = t_q;
        state_d        = S_DONE;
      end

      // Walk: one link read per node, value read alongside
      S_WALK_RD: begin
        p_d            = head_q;
        link_req.re    = 1'b1;
        link_req.raddr = head_q;
        state_d        = S_WALK_NX;
      end
      S_WALK_NX: begin
        if (walk_end || link_rdata == '0) begin
          // Not found: predecessor query answers the last node reached
          if (op_q == OP_FIND_PREVIOUS) begin
            res_idx_d = p_q;
          end
          state_d = S_DONE;
        end else begin
          t_d            = link_rdata;
          link_req.re    = 1'b1;
          link_req.raddr = link_rdata;
          val_re         = 1'b1;
          val_raddr      = link_rdata;
          state_d        = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (val_rdata == val_q) begin
          tn_d = link_rdata;
          case (op_q)
            OP_FIND: begin
              res_idx_d = t_q;
              state_d   = S_DONE;
            end
            OP_DELETE: begin
              res_idx_d  = t_q;
              res_flag_d = 1'b1;
              state_d    = S_DEL_LNK;
            end
            default: begin
              res_idx_d = p_q;
              state_d   = S_DONE;
            end
          endcase
        end else begin
          p_d     = t_q;
          steps_d = steps_q + STEP_BITS'(1);
          state_d = S_WALK_NX;
        end
      end

      // Unlink the matched node and return it to the free list
      S_DEL_LNK: begin
        link_req.we    = 1'b1;
        link_req.waddr = p_q;
        link_req.wdata = tn_q;
        state_d        = S_DEL_FRD;
      end
      S_DEL_FRD: begin
        link_req.re    = 1'b1;
        link_req.raddr = '0;
        state_d        = S_DEL_FWR;
      end
      S_DEL_FWR: begin
        link_req.we    = 1'b1;
        link_req.waddr = t_q;
        link_req.wdata = link_rdata;
        state_d        = S_DEL_FHD;
      end
      S_DEL_FHD: begin
        link_req.we    = 1'b1;
        link_req.waddr = '0;
        link_req.wdata = t_q;
        state_d        = S_DONE;
      end

      // Emptiness / last-node tests
      S_TEST_RD: begin
        link_req.re    = 1'b1;
        link_req.raddr = (op_q == OP_IS_LAST) ? pos_q : head_q;
        state_d        = S_TEST_CHK;
      end
      S_TEST_CHK: begin
        res_flag_d = (link_rdata == '0);
        state_d    = S_DONE;
      end

      // Free a whole list: detach it, then push its nodes one by one
      S_DL_RD: begin
        link_req.re    = 1'b1;
        link_req.raddr = head_q;
        state_d        = S_DL_CUT;
      end
      S_DL_CUT: begin
        p_d            = link_rdata;
        link_req.we    = 1'b1;
        link_req.waddr = head_q;
        link_req.wdata = '0;
        state_d        = S_DL_FRD;
      end
      S_DL_FRD: begin
        link_req.re    = 1'b1;
        link_req.raddr = '0;
        state_d        = S_DL_FCAP;
      end
      S_DL_FCAP: begin
        fh_d    = link_rdata;
        state_d = S_DL_LOOP;
      end
      S_DL_LOOP: begin
        if (p_q == '0 || walk_end) begin
          state_d = S_DL_END;
        end else begin
          link_req.re    = 1'b1;
          link_req.raddr = p_q;
          state_d        = S_DL_STEP;
        end
      end
      S_DL_STEP: begin
        link_req.we    = 1'b1;
        link_req.waddr = p_q;
        link_req.wdata = fh_q;
        fh_d           = p_q;
        p_d            = link_rdata;
        steps_d        = steps_q + STEP_BITS'(1);
        state_d        = S_DL_LOOP;
      end
      S_DL_END: begin
        link_req.we    = 1'b1;
        link_req.waddr = '0;
        link_req.wdata = fh_q;
        state_d        = S_DONE;
      end

      // Hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (out_fire) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_e'(s_axis_tuser);
      head_q <= s_axis_tdata[NODE_BITS-1:0];
      pos_q  <= s_axis_tdata[2*NODE_BITS-1:NODE_BITS];
      val_q  <= s_axis_tdata[2*NODE_BITS+VALUE_BITS-1:2*NODE_BITS];
    end
    p_q          <= p_d;
    t_q          <= t_d;
    tn_q         <= tn_d;
    fh_q         <= fh_d;
    steps_q      <= steps_d;
    res_idx_q    <= res_idx_d;
    res_flag_q   <= res_flag_d;
    res_status_q <= res_status_d;
    if (state_q == S_DONE && out_free) begin
      m_idx_q    <= res_idx_q;
      m_flag_q   <= res_flag_q;
      m_status_q <= res_status_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - NODE_BITS - 1){1'b0}}, m_flag_q, m_idx_q};
  assign m_axis_tuser  = m_status_q;

endmodule

/* rtl/clle_checker.sv */
// ----------------------------------------------------------------------------
// clle_checker
// Port-level checks of the engine's command/result streams, bound to the
// top level.
// ----------------------------------------------------------------------------
module clle_checker
  import clle_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                     m_axis_tuser
);

  // A command transfer makes the engine busy for the next cycle
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine ready right after a command transfer");

  // A new result only follows a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the engine was idle");

  // Out of space carries no node and no flag
  a_no_space_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[NODE_BITS-1:0] == '0 && !m_axis_tdata[NODE_BITS])
    else $error("out-of-space result with node or flag set");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind cursor_linked_list_engine_core clle_checker u_clle_checker (.*);
